// ----- design/uet_pkg.sv -----
// Shared constants, operation codes, controller states and control structs of the edge table.
package uet_pkg;

   // Table capacity and vertex width.
   localparam int MAX_EDGES   = 1024;
   localparam int VERTEX_BITS = 16;

   // Derived widths: entry address, entry count (holds MAX_EDGES itself), stored entry.
   localparam int ADDR_W  = $clog2(MAX_EDGES);
   localparam int COUNT_W = $clog2(MAX_EDGES + 1);
   localparam int EDGE_W  = 2 * VERTEX_BITS;
   localparam int KIND_W  = 2;

   // Operation codes; any other code behaves as a query.
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MOVE_RD,
      ST_MOVE_WR,
      ST_RESULT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic req_ready;    // Take a request beat this cycle.
      logic scan_en;      // Step the table scan.
      logic capture_hit;  // Record the matching entry's position.
      logic commit_miss;  // Apply the outcome of a scan that found nothing.
      logic move_rd;      // Read the last entry.
      logic move_wr;      // Write the last entry into the freed slot.
      logic rsp_load;     // Load the response register.
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_valid;    // A request beat is offered.
      logic match;        // The entry under compare matches the edge.
      logic miss;         // Every entry in use was compared without a match.
      logic is_remove;    // The held operation is a remove.
      logic rsp_free;     // The response register can take a new result.
   } status_type;

endpackage

// ----- design/uet_if.sv -----
// Request and response channel interfaces of the edge table.
interface uet_req_if;
   logic                               valid;
   logic                               ready;
   logic [uet_pkg::KIND_W-1:0]         kind;
   logic [uet_pkg::VERTEX_BITS-1:0]    vertex_a;
   logic [uet_pkg::VERTEX_BITS-1:0]    vertex_b;

   modport source (output valid, output kind, output vertex_a, output vertex_b, input ready);
   modport sink   (input valid, input kind, input vertex_a, input vertex_b, output ready);
endinterface

interface uet_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           found;
   logic                           full_error;
   logic [uet_pkg::COUNT_W-1:0]    edge_count;

   modport source (output valid, output found, output full_error, output edge_count,
                   input ready);
   modport sink   (input valid, input found, input full_error, input edge_count,
                   output ready);
endinterface

// ----- design/uet_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
module uet_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/uet_datapath.sv -----
// Datapath of the edge table: held request, entry store, scan counter and response register.
module uet_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  uet_pkg::cmd_type     cmd,
   output uet_pkg::status_type  status,
   uet_req_if.sink              req,
   uet_rsp_if.source            rsp
);

   // Held request; payload only, no reset needed.
   logic [uet_pkg::KIND_W-1:0]      kind_ff, kind_in;
   logic [uet_pkg::VERTEX_BITS-1:0] a_ff, a_in;
   logic [uet_pkg::VERTEX_BITS-1:0] b_ff, b_in;

   // Table bookkeeping and scan state.
   logic [uet_pkg::COUNT_W-1:0]     count_ff, count_in;
   logic [uet_pkg::COUNT_W-1:0]     pos_ff, pos_in;
   logic                            cmp_valid_ff, cmp_valid_in;
   logic [uet_pkg::ADDR_W-1:0]      hit_pos_ff, hit_pos_in;
   logic                            hit_ff, hit_in;
   logic                            refused_ff, refused_in;

   // Response register.
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_found_ff, rsp_found_in;
   logic                            rsp_full_ff, rsp_full_in;
   logic [uet_pkg::COUNT_W-1:0]     rsp_count_ff, rsp_count_in;

   // Store ports.
   logic                            ram_wr_en;
   logic [uet_pkg::ADDR_W-1:0]      ram_wr_addr;
   logic [uet_pkg::EDGE_W-1:0]      ram_wr_data;
   logic                            ram_rd_en;
   logic [uet_pkg::ADDR_W-1:0]      ram_rd_addr;
   logic [uet_pkg::EDGE_W-1:0]      ram_rd_data;

   logic                            accept;
   logic                            pos_below;
   logic                            issue;
   logic                            entry_match;
   logic                            is_insert;
   logic                            has_room;
   logic                            do_insert;
   logic [uet_pkg::VERTEX_BITS-1:0] entry_first;
   logic [uet_pkg::VERTEX_BITS-1:0] entry_second;
   logic [uet_pkg::COUNT_W-1:0]     pos_prev;
   logic [uet_pkg::COUNT_W-1:0]     last_idx;

   uet_ram #(
      .WIDTH (uet_pkg::EDGE_W),
      .DEPTH (uet_pkg::MAX_EDGES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Request handshake and scan stepping.
   assign req.ready = cmd.req_ready;
   assign accept    = req.valid && cmd.req_ready;
   assign pos_below = pos_ff < count_ff;
   assign issue     = cmd.scan_en && pos_below;
   assign pos_prev  = pos_ff - uet_pkg::COUNT_W'(1);
   assign last_idx  = count_ff - uet_pkg::COUNT_W'(1);

   // Undirected compare: endpoints match in either order.
   assign entry_first  = ram_rd_data[uet_pkg::EDGE_W-1:uet_pkg::VERTEX_BITS];
   assign entry_second = ram_rd_data[uet_pkg::VERTEX_BITS-1:0];
   assign entry_match  = (entry_first == a_ff && entry_second == b_ff) ||
                         (entry_first == b_ff && entry_second == a_ff);

   // Insert decision after a scan that found nothing.
   assign is_insert = kind_ff == uet_pkg::KIND_INSERT;
   assign has_room  = count_ff < uet_pkg::COUNT_W'(uet_pkg::MAX_EDGES);
   assign do_insert = cmd.commit_miss && is_insert && has_room;

   // Store port steering: scan or last-entry read, append or slot refill write.
   assign ram_rd_en   = issue || cmd.move_rd;
   assign ram_rd_addr = cmd.move_rd ? last_idx[uet_pkg::ADDR_W-1:0]
                                    : pos_ff[uet_pkg::ADDR_W-1:0];
   assign ram_wr_en   = do_insert || cmd.move_wr;
   assign ram_wr_addr = cmd.move_wr ? hit_pos_ff : count_ff[uet_pkg::ADDR_W-1:0];
   assign ram_wr_data = cmd.move_wr ? ram_rd_data : {a_ff, b_ff};

   // Status to the controller.
   always_comb begin
      status.req_valid = req.valid;
      status.match     = cmp_valid_ff && entry_match;
      status.miss      = !cmp_valid_ff && !pos_below;
      status.is_remove = kind_ff == uet_pkg::KIND_REMOVE;
      status.rsp_free  = !rsp_valid_ff || rsp.ready;
   end

   // Next values of the held request and the scan state.
   always_comb begin
      kind_in      = kind_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      pos_in       = pos_ff;
      cmp_valid_in = cmd.scan_en ? issue : 1'b0;
      hit_pos_in   = hit_pos_ff;
      hit_in       = hit_ff;
      refused_in   = refused_ff;
      count_in     = count_ff;
      if (accept) begin
         kind_in    = req.kind;
         a_in       = req.vertex_a;
         b_in       = req.vertex_b;
         pos_in     = '0;
         hit_in     = 1'b0;
         refused_in = 1'b0;
      end
      if (issue) begin
         pos_in = pos_ff + uet_pkg::COUNT_W'(1);
      end
      if (cmd.capture_hit) begin
         hit_pos_in = pos_prev[uet_pkg::ADDR_W-1:0];
         hit_in     = 1'b1;
      end
      if (cmd.commit_miss && is_insert && !has_room) begin
         refused_in = 1'b1;
      end
      if (do_insert) begin
         count_in = count_ff + uet_pkg::COUNT_W'(1);
      end else if (cmd.move_wr) begin
         count_in = last_idx;
      end
   end

   // Next values of the response register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_count_in = rsp_count_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = hit_ff;
         rsp_full_in  = refused_ff;
         rsp_count_in = count_ff;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      pos_ff       <= pos_in;
      hit_pos_ff   <= hit_pos_in;
      hit_ff       <= hit_in;
      refused_ff   <= refused_in;
      rsp_found_ff <= rsp_found_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.found      = rsp_found_ff;
   assign rsp.full_error = rsp_full_ff;
   assign rsp.edge_count = rsp_count_ff;

   // The count never passes the capacity.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= uet_pkg::COUNT_W'(uet_pkg::MAX_EDGES))
      else $error("edge count above capacity");

   // The count moves by at most one entry per cycle.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff) ||
                         count_ff == $past(count_ff) + uet_pkg::COUNT_W'(1) ||
                         count_ff == $past(count_ff) - uet_pkg::COUNT_W'(1)))
      else $error("edge count jumped");

   // A slot refill targets an entry in use.
   assert property (@(posedge clock) disable iff (reset)
      cmd.move_wr |-> ({1'b0, hit_pos_ff} < count_ff))
      else $error("refill outside the entries in use");

   // A response never reports both a present edge and a refused insert.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_found_ff && rsp_full_ff))
      else $error("found and full_error both set");

endmodule

// ----- design/uet_controller.sv -----
// Controller state machine that sequences scan, removal refill and response of the edge table.
module uet_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  uet_pkg::status_type  status,
   output uet_pkg::cmd_type     cmd
);

   uet_pkg::state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= uet_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         uet_pkg::ST_IDLE: begin
            if (status.req_valid) begin
               state_in = uet_pkg::ST_SCAN;
            end
         end
         uet_pkg::ST_SCAN: begin
            if (status.match && status.is_remove) begin
               state_in = uet_pkg::ST_MOVE_RD;
            end else if (status.match || status.miss) begin
               state_in = uet_pkg::ST_RESULT;
            end
         end
         uet_pkg::ST_MOVE_RD: begin
            state_in = uet_pkg::ST_MOVE_WR;
         end
         uet_pkg::ST_MOVE_WR: begin
            state_in = uet_pkg::ST_RESULT;
         end
         uet_pkg::ST_RESULT: begin
            if (status.rsp_free) begin
               state_in = uet_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = uet_pkg::ST_IDLE;
         end
      endcase
   end

   // Commands for each state.
   always_comb begin
      cmd = '0;
      case (state_ff)
         uet_pkg::ST_IDLE: begin
            cmd.req_ready = 1'b1;
         end
         uet_pkg::ST_SCAN: begin
            cmd.scan_en     = 1'b1;
            cmd.capture_hit = status.match;
            cmd.commit_miss = status.miss;
         end
         uet_pkg::ST_MOVE_RD: begin
            cmd.move_rd = 1'b1;
         end
         uet_pkg::ST_MOVE_WR: begin
            cmd.move_wr = 1'b1;
         end
         uet_pkg::ST_RESULT: begin
            cmd.rsp_load = status.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ----- design/undirected_edge_table_core.sv -----
// Top level of the undirected edge table: controller, datapath and entry store.
//
// The request channel carries one operation per beat: kind (insert, remove,
// or query for any other code) and the two endpoints of an edge. Edges are
// undirected, so the two endpoints match in either order.
// The response channel returns one beat per request: found (edge was present
// before the operation), full_error (an insert of a new edge was refused at
// capacity) and edge_count (entries held after the operation).
// Each request scans the entries in use one per cycle through the store's
// single read port, so the scan sets the rate. A remove that hits then
// reads the last entry and writes it into the freed slot before the
// response is loaded. The next request beat can be taken at the same edge
// as the response beat of the previous request.
// A finished response sits in an output register; the next request is taken
// while it waits, and its scan proceeds, but its own response is held back
// until the receiver has taken the previous beat.
// Reset clears the entry count and the response valid state; stored entries
// are not cleared, and only entries below the count are ever read.
module undirected_edge_table_core (
   input  logic        clock,
   input  logic        reset,
   uet_req_if.sink     req,
   uet_rsp_if.source   rsp
);

   uet_pkg::cmd_type    cmd;
   uet_pkg::status_type status;

   uet_controller u_controller (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   uet_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .status (status),
      .req    (req),
      .rsp    (rsp)
   );

endmodule

// ----- sim/undirected_edge_table_checker.sv -----
// Checker for the edge table: watches both channels, predicts every response beat and compares it.
`timescale 1ns / 100ps

module undirected_edge_table_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [uet_pkg::KIND_W-1:0]        req_kind,
   input  logic [uet_pkg::VERTEX_BITS-1:0]   req_vertex_a,
   input  logic [uet_pkg::VERTEX_BITS-1:0]   req_vertex_b,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic                              rsp_found,
   input  logic                              rsp_full_error,
   input  logic [uet_pkg::COUNT_W-1:0]       rsp_edge_count,
   output int                                error_count,
   output int                                outstanding,
   output int                                edge_level
);

   typedef struct packed {
      logic                        found;
      logic                        full_error;
      logic [uet_pkg::COUNT_W-1:0] edge_count;
   } edge_answer_type;

   // Shadow copy of the table: both endpoints of every entry and the entry count.
   logic [uet_pkg::VERTEX_BITS-1:0] stored_first  [uet_pkg::MAX_EDGES];
   logic [uet_pkg::VERTEX_BITS-1:0] stored_second [uet_pkg::MAX_EDGES];
   int                              stored_count;

   // Responses owed for request beats taken so far, oldest first.
   edge_answer_type answers_due [$];
   edge_answer_type want;

   // Applies one operation to the shadow table and returns the response it must produce.
   function automatic edge_answer_type apply_edge_op(
      input logic [uet_pkg::KIND_W-1:0]      kind,
      input logic [uet_pkg::VERTEX_BITS-1:0] a,
      input logic [uet_pkg::VERTEX_BITS-1:0] b);
      int              pos;
      logic            hit;
      edge_answer_type ans;
      pos = 0;
      hit = 1'b0;
      // Scan the entries in use; endpoints match in either order.
      while (pos < stored_count && !hit) begin
         if ((stored_first[pos] == a && stored_second[pos] == b) ||
             (stored_first[pos] == b && stored_second[pos] == a))
            hit = 1'b1;
         else
            pos++;
      end
      ans = '0;
      ans.found = hit;
      if (kind == uet_pkg::KIND_INSERT && !hit) begin
         // A new edge goes at the end, unless the table is already full.
         if (stored_count < uet_pkg::MAX_EDGES) begin
            stored_first[stored_count]  = a;
            stored_second[stored_count] = b;
            stored_count++;
         end else begin
            ans.full_error = 1'b1;
         end
      end else if (kind == uet_pkg::KIND_REMOVE && hit) begin
         // The last entry fills the freed slot.
         stored_count--;
         stored_first[pos]  = stored_first[stored_count];
         stored_second[pos] = stored_second[stored_count];
      end
      ans.edge_count = uet_pkg::COUNT_W'(stored_count);
      return ans;
   endfunction

   // Response beats are checked before the request beat of the same edge is predicted.
   always @(posedge clock) begin
      if (reset) begin
         stored_count = 0;
         error_count  = 0;
         answers_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (answers_due.size() == 0) begin
               $error("response beat with no request outstanding");
               error_count++;
            end else begin
               want = answers_due.pop_front();
               if (rsp_found !== want.found) begin
                  $error("found: expected %0b, got %0b", want.found, rsp_found);
                  error_count++;
               end
               if (rsp_full_error !== want.full_error) begin
                  $error("full_error: expected %0b, got %0b", want.full_error, rsp_full_error);
                  error_count++;
               end
               if (rsp_edge_count !== want.edge_count) begin
                  $error("edge_count: expected %0d, got %0d", want.edge_count, rsp_edge_count);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready)
            answers_due.push_back(apply_edge_op(req_kind, req_vertex_a, req_vertex_b));
      end
      outstanding = answers_due.size();
      edge_level  = stored_count;
   end

endmodule

// ----- sim/undirected_edge_table_core_tb.sv -----
// Testbench top of the edge table: clock, reset, request stimulus, response back-pressure and verdict.
`timescale 1ns / 100ps

module undirected_edge_table_core_tb;

   // Codes that the block treats as queries.
   localparam logic [uet_pkg::KIND_W-1:0] KIND_QUERY = 2'd2;
   localparam logic [uet_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;

   localparam int RANDOM_ITEMS   = 580;
   localparam int POOL_SIZE      = 12;
   localparam int TAIL_CYCLES    = uet_pkg::MAX_EDGES + 16;
   localparam int WATCHDOG_LIMIT = 10 * (uet_pkg::MAX_EDGES + 8);

   typedef logic [uet_pkg::VERTEX_BITS-1:0] vtx_type;

   logic    clock;
   logic    reset;
   logic    tx_idle;
   logic    rx_idle;
   int      error_count;
   int      outstanding;
   int      edge_level;
   int      stall_cycles;
   vtx_type pool [POOL_SIZE];
   vtx_type first_a, first_b, last_a, last_b;

   uet_req_if req_ch ();
   uet_rsp_if rsp_ch ();

   undirected_edge_table_core i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   undirected_edge_table_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_ch.valid),
      .req_ready      (req_ch.ready),
      .req_kind       (req_ch.kind),
      .req_vertex_a   (req_ch.vertex_a),
      .req_vertex_b   (req_ch.vertex_b),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_found      (rsp_ch.found),
      .rsp_full_error (rsp_ch.full_error),
      .rsp_edge_count (rsp_ch.edge_count),
      .error_count    (error_count),
      .outstanding    (outstanding),
      .edge_level     (edge_level)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The receiver stalls about one cycle in four while its idling is on.
   always @(negedge clock) begin
      rsp_ch.ready <= rx_idle ? ($urandom_range(99) >= 25) : 1'b1;
   end

   // Watchdog: too many cycles without any beat on either channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("undirected_edge_table_core_tb: errors");
            $finish;
         end
      end
   end

   // Offers one request beat, after an optional idle gap, and returns once it is taken.
   task automatic send_op(input logic [uet_pkg::KIND_W-1:0] kind, input vtx_type a,
                          input vtx_type b);
      int gap;
      gap = (tx_idle && $urandom_range(99) < 25) ? $urandom_range(1, 3) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid    <= 1'b1;
      req_ch.kind     <= kind;
      req_ch.vertex_a <= a;
      req_ch.vertex_b <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Holds the request channel idle until every owed response beat has arrived.
   task automatic drain_responses();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // Mostly inserts and removes, some queries, and a few of the spare code.
   function automatic logic [uet_pkg::KIND_W-1:0] pick_kind();
      int r;
      r = $urandom_range(99);
      if (r < 45)
         return uet_pkg::KIND_INSERT;
      else if (r < 75)
         return uet_pkg::KIND_REMOVE;
      else if (r < 95)
         return KIND_QUERY;
      return KIND_SPARE;
   endfunction

   // Vertices come mostly from a small pool so that edges repeat and removes hit.
   function automatic vtx_type pick_vertex();
      if ($urandom_range(99) < 85)
         return pool[$urandom_range(POOL_SIZE - 1)];
      return vtx_type'($urandom);
   endfunction

   initial begin
      reset           = 1'b1;
      tx_idle         = 1'b0;
      rx_idle         = 1'b0;
      req_ch.valid    = 1'b0;
      req_ch.kind     = uet_pkg::KIND_INSERT;
      req_ch.vertex_a = '0;
      req_ch.vertex_b = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Directed: empty table, duplicates, swapped endpoints, extremes, removes
      // from the middle and from the end, absent edges and the spare code.
      send_op(KIND_QUERY,           16'h0000, 16'h0000);
      send_op(uet_pkg::KIND_REMOVE, 16'h0000, 16'h0000);
      send_op(uet_pkg::KIND_INSERT, 16'h0000, 16'h0000);
      send_op(uet_pkg::KIND_INSERT, 16'h0000, 16'h0000);
      send_op(uet_pkg::KIND_INSERT, 16'hFFFF, 16'h0000);
      send_op(KIND_QUERY,           16'h0000, 16'hFFFF);
      send_op(uet_pkg::KIND_INSERT, 16'h0000, 16'hFFFF);
      send_op(uet_pkg::KIND_INSERT, 16'hFFFF, 16'hFFFF);
      send_op(uet_pkg::KIND_INSERT, 16'h1234, 16'hABCD);
      send_op(KIND_SPARE,           16'hABCD, 16'h1234);
      send_op(uet_pkg::KIND_REMOVE, 16'h0000, 16'hFFFF);
      send_op(KIND_QUERY,           16'h1234, 16'hABCD);
      send_op(uet_pkg::KIND_REMOVE, 16'h0001, 16'h0002);
      send_op(KIND_SPARE,           16'h0007, 16'h0007);
      send_op(uet_pkg::KIND_INSERT, 16'hAAAA, 16'h5555);
      send_op(uet_pkg::KIND_INSERT, 16'h5555, 16'hAAAA);
      send_op(uet_pkg::KIND_REMOVE, 16'h5555, 16'hAAAA);
      send_op(uet_pkg::KIND_REMOVE, 16'hFFFF, 16'hFFFF);
      send_op(uet_pkg::KIND_REMOVE, 16'hABCD, 16'h1234);
      send_op(uet_pkg::KIND_REMOVE, 16'h0000, 16'h0000);
      send_op(KIND_QUERY,           16'hFFFF, 16'hFFFF);

      // Random operations on a small table, with a stretch of no idling in the middle.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) begin
            foreach (pool[i]) pool[i] = vtx_type'($urandom);
         end
         tx_idle = (n < 200 || n >= 380);
         rx_idle = tx_idle;
         if (n == 290)
            drain_responses();
         send_op(pick_kind(), pick_vertex(), pick_vertex());
      end

      // Fill the table to capacity, one insert at a time.
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      drain_responses();
      first_a = vtx_type'($urandom);
      first_b = vtx_type'($urandom);
      last_a  = first_a;
      last_b  = first_b;
      send_op(uet_pkg::KIND_INSERT, first_a, first_b);
      drain_responses();
      while (edge_level < uet_pkg::MAX_EDGES) begin
         last_a = vtx_type'($urandom);
         last_b = vtx_type'($urandom);
         send_op(uet_pkg::KIND_INSERT, last_a, last_b);
         drain_responses();
      end

      // Full table: refused insert, present insert, remove and refill.
      send_op(uet_pkg::KIND_INSERT, vtx_type'($urandom), vtx_type'($urandom));
      send_op(uet_pkg::KIND_INSERT, last_a, last_b);
      send_op(KIND_QUERY,           first_b, first_a);
      send_op(KIND_SPARE,           vtx_type'($urandom), vtx_type'($urandom));
      send_op(uet_pkg::KIND_REMOVE, first_a, first_b);
      send_op(KIND_QUERY,           last_b, last_a);
      send_op(uet_pkg::KIND_INSERT, first_a, first_b);
      send_op(uet_pkg::KIND_REMOVE, vtx_type'($urandom), vtx_type'($urandom));
      send_op(uet_pkg::KIND_INSERT, vtx_type'($urandom), vtx_type'($urandom));

      // Wait out every owed beat, then give stray beats a chance to show.
      drain_responses();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (error_count == 0)
         $display("undirected_edge_table_core_tb: clean");
      else
         $display("undirected_edge_table_core_tb: errors");
      $finish;
   end

endmodule
